@@ rtl/hns_pkg.sv @@
// shared types, constants and segment lookup for the hex number segment sequencer
package hns_pkg;

  localparam int DIGITS_DEF = 8;
  localparam int NUMBER_W   = 32;
  localparam int START_W    = 4;
  localparam int NIB_W      = 4;
  localparam int POS_W      = 3;
  localparam int BYTE_W     = 8;

  localparam logic [BYTE_W-1:0] CMD_BASE = 8'hC0;

  typedef logic [NIB_W-1:0]  nib_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    nib_t nib;
    pos_t pos;
    logic last;
  } digit_t;

  function automatic byte_t seg_of(input nib_t nib);
    byte_t seg;
    unique case (nib)
      4'h0:    seg = 8'h3F;
      4'h1:    seg = 8'h06;
      4'h2:    seg = 8'h5B;
      4'h3:    seg = 8'h4F;
      4'h4:    seg = 8'h66;
      4'h5:    seg = 8'h6D;
      4'h6:    seg = 8'h7D;
      4'h7:    seg = 8'h07;
      4'h8:    seg = 8'h7F;
      4'h9:    seg = 8'h6F;
      4'hA:    seg = 8'h77;
      4'hB:    seg = 8'h7C;
      4'hC:    seg = 8'h58;
      4'hD:    seg = 8'h5E;
      4'hE:    seg = 8'h79;
      default: seg = 8'h71;
    endcase
    return seg;
  endfunction

  function automatic byte_t cmd_of(input pos_t pos);
    return CMD_BASE | {{(BYTE_W-POS_W-1){1'b0}}, pos, 1'b0};
  endfunction

endpackage

@@ rtl/hns_channels.sv @@
// valid/ready channel interfaces for number input and digit results
interface hns_in_if;
  logic                          valid;
  logic                          ready;
  logic [hns_pkg::NUMBER_W-1:0]  number;
  logic [hns_pkg::START_W-1:0]   start_pos;

  modport source (output valid, output number, output start_pos, input ready);
  modport sink   (input valid, input number, input start_pos, output ready);
endinterface

interface hns_out_if;
  logic                        valid;
  logic                        ready;
  logic [hns_pkg::BYTE_W-1:0]  command_byte;
  logic [hns_pkg::BYTE_W-1:0]  segments;
  logic                        last;

  modport source (output valid, output command_byte, output segments, output last,
                  input ready);
  modport sink   (input valid, input command_byte, input segments, input last,
                  output ready);
endinterface

@@ rtl/hns_shift.sv @@
// nibble shift register: loads a number, drops leading zero nibbles, hands out digits
module hns_shift #(
  parameter int DIGITS = hns_pkg::DIGITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  hns_in_if.sink           in_ch,
  output logic             dig_valid,
  input  logic             dig_ready,
  output hns_pkg::digit_t  dig
);

  localparam int SH_W  = DIGITS * hns_pkg::NIB_W;
  localparam int CNT_W = $clog2(DIGITS + 1);

  typedef enum logic [1:0] {S_IDLE, S_SKIP, S_EMIT} state_t;

  state_t               state_r, state_nxt;
  logic [SH_W-1:0]      sh_r, sh_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  hns_pkg::pos_t        pos_r, pos_nxt;
  hns_pkg::nib_t        top_nib;

  assign top_nib   = sh_r[SH_W-1 -: hns_pkg::NIB_W];
  assign in_ch.ready = (state_r == S_IDLE);
  assign dig_valid = (state_r == S_EMIT);
  assign dig.nib   = top_nib;
  assign dig.pos   = pos_r;
  assign dig.last  = (cnt_r == CNT_W'(1));

  always_comb begin
    state_nxt = state_r;
    sh_nxt    = sh_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          sh_nxt    = in_ch.number[SH_W-1:0];
          cnt_nxt   = CNT_W'(DIGITS);
          pos_nxt   = in_ch.start_pos[hns_pkg::START_W-1] ? '0
                                                          : in_ch.start_pos[hns_pkg::POS_W-1:0];
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        if (top_nib == '0 && cnt_r > CNT_W'(1)) begin
          sh_nxt  = sh_r << hns_pkg::NIB_W;
          cnt_nxt = cnt_r - CNT_W'(1);
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (dig_ready) begin
          sh_nxt  = sh_r << hns_pkg::NIB_W;
          cnt_nxt = cnt_r - CNT_W'(1);
          pos_nxt = pos_r + hns_pkg::POS_W'(1);
          if (cnt_r == CNT_W'(1)) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    sh_r  <= sh_nxt;
    cnt_r <= cnt_nxt;
    pos_r <= pos_nxt;
  end

endmodule

@@ rtl/hns_out.sv @@
// segment encode and output register for digit results
module hns_out (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             dig_valid,
  output logic             dig_ready,
  input  hns_pkg::digit_t  dig,
  hns_out_if.source        out_ch
);

  logic           valid_r;
  hns_pkg::byte_t cmd_r;
  hns_pkg::byte_t seg_r;
  logic           last_r;

  assign dig_ready           = !valid_r || out_ch.ready;
  assign out_ch.valid        = valid_r;
  assign out_ch.command_byte = cmd_r;
  assign out_ch.segments     = seg_r;
  assign out_ch.last         = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (dig_valid && dig_ready) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
    if (dig_valid && dig_ready) begin
      cmd_r  <= hns_pkg::cmd_of(dig.pos);
      seg_r  <= hns_pkg::seg_of(dig.nib);
      last_r <= dig.last;
    end
  end

endmodule

@@ rtl/hex_number_segment_sequencer.sv @@
// top level of the hex number to seven-segment digit sequencer
//
//   channel  dir  payload                            handshake
//   in_ch    in   number[31:0], start_pos[3:0]       valid/ready
//   out_ch   out  command_byte, segments, last       valid/ready
//
// one item at a time: the number is loaded, leading zero nibbles are dropped one by one,
// the first digit is found, then one digit result per cycle while the output does not
// stall; the nibble shift register sets this pace and takes no new item until it is done
// reset is synchronous, active low, and clears the sequencer and output valid
// a stalled output holds the result register and pauses the shift register
module hex_number_segment_sequencer #(
  parameter int DIGITS = hns_pkg::DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  hns_in_if.sink     in_ch,
  hns_out_if.source  out_ch
);

  logic            dig_valid;
  logic            dig_ready;
  hns_pkg::digit_t dig;

  hns_shift #(.DIGITS(DIGITS)) u_shift (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .dig_valid (dig_valid),
    .dig_ready (dig_ready),
    .dig       (dig)
  );

  hns_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .dig_valid (dig_valid),
    .dig_ready (dig_ready),
    .dig       (dig),
    .out_ch    (out_ch)
  );

endmodule

@@ dv/tb_hex_number_segment_sequencer.sv @@
// testbench for the hex number segment sequencer: predicted digit results, random stalls
`timescale 1ns / 100ps

module tb_hex_number_segment_sequencer;

  localparam int DIGITS       = hns_pkg::DIGITS_DEF;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 2 * DIGITS + 8;
  localparam int MAX_REPORTS  = 10;

  // patterns for digits 0 to f, digit 0 in the low byte
  localparam logic [127:0] SEG_ROM = {
    8'h71, 8'h79, 8'h5E, 8'h58, 8'h7C, 8'h77, 8'h6F, 8'h7F,
    8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };

  typedef struct packed {
    hns_pkg::byte_t command_byte;
    hns_pkg::byte_t segments;
    logic           last;
  } digit_exp_t;

  logic clk;
  logic rst_n;

  hns_in_if  in_ch ();
  hns_out_if out_ch ();

  hex_number_segment_sequencer #(.DIGITS(DIGITS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  digit_exp_t digit_q[$];
  int  send_idle_pct;
  int  recv_idle_pct;
  int  error_count;
  int  numbers_sent;
  int  digits_seen;
  int  cycle_count;
  int  hold_count;
  logic long_hold;
  logic hold_done;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void predict_digits(input logic [hns_pkg::NUMBER_W-1:0] num,
                                         input logic [hns_pkg::START_W-1:0] sp);
    int             count;
    hns_pkg::pos_t  pos;
    hns_pkg::nib_t  nib;
    digit_exp_t     d;
    count = DIGITS;
    while (count > 1 && num[4*(count-1) +: 4] == 4'h0)
      count--;
    pos = sp[3] ? 3'd0 : sp[2:0];
    for (int k = count - 1; k >= 0; k--) begin
      nib            = num[4*k +: 4];
      d.command_byte = hns_pkg::CMD_BASE | {4'b0000, pos, 1'b0};
      d.segments     = SEG_ROM[nib*8 +: 8];
      d.last         = (k == 0);
      digit_q.push_back(d);
      pos++;
    end
  endfunction

  // called at a rising edge; leaves valid high after the item is taken
  task automatic send_number(input logic [hns_pkg::NUMBER_W-1:0] num,
                             input logic [hns_pkg::START_W-1:0] sp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.number    <= num;
    in_ch.start_pos <= sp;
    do @(posedge clk); while (!in_ch.ready);
    predict_digits(num, sp);
    numbers_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (digit_q.size() != 0)
      @(posedge clk);
    @(posedge clk);
  endtask

  function automatic logic [hns_pkg::NUMBER_W-1:0] random_number();
    logic [hns_pkg::NUMBER_W-1:0] num;
    int                           nibs;
    int                           pick;
    pick = $urandom_range(99);
    nibs = $urandom_range(1, DIGITS);
    num  = $urandom;
    if (pick < 8)
      num = '0;
    else if (pick < 14)
      num = '1;
    else if (nibs < 8)
      num = num & ((32'h1 << (4 * nibs)) - 1);
    return num;
  endfunction

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic test_directed();
    send_number(32'h0000_0000, 4'd0);
    send_number(32'h0000_0000, 4'd7);
    send_number(32'h0000_0000, 4'd8);
    send_number(32'h0000_0000, 4'd15);
    send_number(32'hFFFF_FFFF, 4'd0);
    send_number(32'hFFFF_FFFF, 4'd15);
    send_number(32'h0123_4567, 4'd3);
    send_number(32'h89AB_CDEF, 4'd1);
    send_number(32'hFEDC_BA98, 4'd7);
    send_number(32'h8000_0000, 4'd5);
    send_number(32'h0000_0001, 4'd9);
    send_number(32'h0000_000F, 4'd4);
    send_number(32'h0C0C_0C0C, 4'd0);
    send_number(32'h5555_5555, 4'd10);
    send_number(32'hAAAA_AAAA, 4'd6);
    send_number(32'h1234_5678, 4'd12);
    for (int k = 0; k < DIGITS; k++)
      send_number(32'(k + 8) << (4 * k), 4'(15 - k));
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++)
      send_number(random_number(), 4'($urandom_range(0, 15)));
  endtask

  // receiver stops for a long stretch while items keep coming
  task automatic test_long_hold();
    long_hold <= 1'b1;
    for (int i = 0; i < 10; i++)
      send_number(32'hF000_0000 | $urandom, 4'($urandom_range(0, 15)));
    while (!hold_done)
      @(posedge clk);
    long_hold <= 1'b0;
  endtask

  task automatic test_drain_pause();
    test_random(5);
    wait_drained();
    test_random(5);
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    hold_count = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (!long_hold) begin
        hold_count = 0;
        hold_done  = 1'b0;
      end
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (long_hold && !hold_done) begin
        out_ch.ready <= 1'b0;
        hold_count++;
        if (hold_count >= HOLD_CYCLES)
          hold_done = 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    digit_exp_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      digits_seen++;
      if (digit_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected digit: cmd %h seg %h last %b",
                   out_ch.command_byte, out_ch.segments, out_ch.last);
      end else begin
        want = digit_q.pop_front();
        if (out_ch.command_byte !== want.command_byte || out_ch.segments !== want.segments ||
            out_ch.last !== want.last) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("digit mismatch: expected cmd %h seg %h last %b, got cmd %h seg %h last %b",
                     want.command_byte, want.segments, want.last,
                     out_ch.command_byte, out_ch.segments, out_ch.last);
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.number    <= '0;
    in_ch.start_pos <= '0;
    long_hold       <= 1'b0;
    error_count  = 0;
    numbers_sent = 0;
    digits_seen  = 0;
    set_idle(15, 76);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(130);
    test_long_hold();
    test_drain_pause();
    set_idle(76, 15);
    test_random(130);
    set_idle(0, 0);
    test_random(130);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (digit_q.size() != 0)
      error_count++;
    $display("sent %0d numbers, checked %0d digit results", numbers_sent, digits_seen);
    $display("zero and full values, wrapped and out-of-range start positions, long stalls");
    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ files.f @@
rtl/hns_pkg.sv
rtl/hns_channels.sv
rtl/hns_shift.sv
rtl/hns_out.sv
rtl/hex_number_segment_sequencer.sv
dv/tb_hex_number_segment_sequencer.sv
